### rtl/agc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// agc_pkg
// Types and constants shared by the adaptive gain clipper modules.
// ----------------------------------------------------------------------------
package agc_pkg;

    localparam int SAMPLE_W       = 32;
    localparam int MAG_W          = 32;
    localparam int OUT_W          = 16;
    localparam int PEAK_W         = 15;
    localparam int GAIN_W         = 17;
    localparam int FRAC_W         = 16;
    localparam int PROD_W         = MAG_W + GAIN_W;
    localparam int EXCESS_W       = 48;
    localparam int CFG_FRAMES_W   = 13;
    localparam int CFG_RETAIN_W   = 10;
    localparam int CFG_STRENGTH_W = 16;
    localparam int F_W            = CFG_FRAMES_W + 15;
    localparam int ACC_W          = CFG_STRENGTH_W + EXCESS_W;
    localparam int DEN_W          = ACC_W - 8 + 1;
    localparam int REM_W          = F_W + FRAC_W;
    localparam int DSH_W          = DEN_W + FRAC_W;
    localparam int QUO_W          = GAIN_W;
    localparam int ADDR_W         = 4;
    localparam int DATA_W         = 32;

    localparam logic [GAIN_W-1:0]   GAIN_ONE = 17'h10000;
    localparam logic [MAG_W-1:0]    POS_LIMIT = 32'd32767;
    localparam logic [MAG_W-1:0]    NEG_LIMIT = 32'd32768;
    localparam logic [OUT_W-1:0]    OUT_POS_CLIP = 16'h7FFF;
    localparam logic [OUT_W-1:0]    OUT_NEG_CLIP = 16'h8000;
    localparam logic [PEAK_W-1:0]   PEAK_FULL = 15'h7FFF;

    localparam logic [1:0] REG_FRAMES   = 2'd0;
    localparam logic [1:0] REG_RETAIN   = 2'd1;
    localparam logic [1:0] REG_STRENGTH = 2'd2;

    typedef struct packed {
        logic             neg;
        logic [MAG_W-1:0] mag;
        logic             last;
    } t_item;

    typedef struct packed {
        logic [CFG_FRAMES_W-1:0]   frames;
        logic [CFG_RETAIN_W-1:0]   retain;
        logic [CFG_STRENGTH_W-1:0] strength;
    } t_cfg;

    typedef struct packed {
        logic  push;
        logic  pop;
    } t_qctl;

    typedef struct packed {
        logic  full;
        logic  empty;
    } t_qsts;

endpackage

### rtl/agc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// agc_front
// Accepts input words, takes sign and magnitude and marks the last word of
// each chunk.
// ----------------------------------------------------------------------------
module agc_front #(
    parameter int WC_W = 13
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    input  logic signed [agc_pkg::SAMPLE_W-1:0]    i_mixed_sample,
    output logic                                   o_stall,
    input  logic [agc_pkg::CFG_FRAMES_W-1:0]       i_frames,
    input  logic                                   i_full,
    output logic                                   o_push,
    output agc_pkg::t_item                         o_item
);
    import agc_pkg::*;

    localparam int LAST_W = CFG_FRAMES_W + 1;
    localparam int CMP_W  = (WC_W > LAST_W) ? WC_W : LAST_W;

    logic [WC_W-1:0]   r_wc;
    logic [WC_W-1:0]   n_wc;
    logic [LAST_W-1:0] w_last_idx;
    logic              w_is_last;
    logic              w_accept;

    assign w_last_idx = {i_frames, 1'b0} - LAST_W'(1);
    assign w_is_last  = CMP_W'(r_wc) >= CMP_W'(w_last_idx);
    assign w_accept   = i_valid && !i_full;
    assign o_stall    = i_full;
    assign o_push     = w_accept;

    assign o_item.neg  = i_mixed_sample[SAMPLE_W-1];
    assign o_item.mag  = i_mixed_sample[SAMPLE_W-1] ? MAG_W'(-i_mixed_sample)
                                                    : MAG_W'(i_mixed_sample);
    assign o_item.last = w_is_last;

    always_comb begin
        n_wc = r_wc;
        if (w_accept) begin
            n_wc = w_is_last ? '0 : r_wc + WC_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wc <= '0;
        end else begin
            r_wc <= n_wc;
        end
    end

endmodule

### rtl/agc_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// agc_fifo
// Two-entry queue between the front and back parts.
// ----------------------------------------------------------------------------
module agc_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  agc_pkg::t_qctl  i_ctl,
    input  agc_pkg::t_item  i_item,
    output agc_pkg::t_qsts  o_sts,
    output agc_pkg::t_item  o_item
);
    import agc_pkg::*;

    t_item      r_mem [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;
    logic       w_push;
    logic       w_pop;

    assign o_sts.full  = (r_cnt == 2'd2);
    assign o_sts.empty = (r_cnt == 2'd0);
    assign w_push      = i_ctl.push && !o_sts.full;
    assign w_pop       = i_ctl.pop && !o_sts.empty;
    assign o_item      = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr <= ~r_wr;
            end
            if (w_pop) begin
                r_rd <= ~r_rd;
            end
            case ({w_push, w_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

### rtl/agc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// agc_back
// Applies the gain, clips, tracks excess and peak, and runs the chunk-end
// gain update on a sequenced multiplier and a shared restoring divider.
// ----------------------------------------------------------------------------
module agc_back (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  agc_pkg::t_cfg                        i_cfg,
    input  agc_pkg::t_qsts                       i_qsts,
    input  agc_pkg::t_item                       i_item,
    output logic                                 o_pop,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic signed [agc_pkg::OUT_W-1:0]     o_clipped_sample,
    output logic                                 o_was_clipped,
    output logic                                 o_chunk_end,
    output logic [agc_pkg::PEAK_W-1:0]           o_chunk_peak,
    output logic [agc_pkg::GAIN_W-1:0]           o_gain_used
);
    import agc_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CLIP = 3'd1;
    localparam logic [2:0] S_MULX = 3'd2;
    localparam logic [2:0] S_DEN  = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_AVG  = 3'd5;
    localparam logic [2:0] S_GAIN = 3'd6;

    logic [2:0]                r_state;
    logic [MAG_W-1:0]          r_pm;
    logic                      r_neg;
    logic                      r_last;
    logic [GAIN_W-1:0]         r_gain;
    logic [GAIN_W-1:0]         r_gain_used;
    logic [EXCESS_W-1:0]       r_excess;
    logic [PEAK_W-1:0]         r_peak;
    logic                      r_ov;
    logic [OUT_W-1:0]          r_out_sample;
    logic                      r_out_clip;
    logic                      r_out_end;
    logic [PEAK_W-1:0]         r_out_peak;
    logic [GAIN_W-1:0]         r_out_gain;
    logic [F_W-1:0]            r_f;
    logic [CFG_STRENGTH_W-1:0] r_str;
    logic [CFG_RETAIN_W-1:0]   r_ret;
    logic [ACC_W-1:0]          r_acc;
    logic [1:0]                r_k;
    logic [DSH_W-1:0]          r_dsh;
    logic [REM_W-1:0]          r_rem;
    logic [QUO_W-1:0]          r_q;
    logic [4:0]                r_cnt;
    logic                      r_phase;

    logic [PROD_W-1:0]         w_prod;
    logic                      w_out_free;
    logic                      w_load;
    logic                      w_pos_clip;
    logic                      w_neg_clip;
    logic [MAG_W-1:0]          w_exc;
    logic [EXCESS_W:0]         w_sum;
    logic [EXCESS_W-1:0]       w_new_excess;
    logic [OUT_W-1:0]          w_sample;
    logic [PEAK_W-1:0]         w_new_peak;
    logic [F_W-1:0]            w_f;
    logic [ACC_W-1:0]          w_pp;
    logic [DEN_W-1:0]          w_den;
    logic                      w_ge;
    logic [REM_W-1:0]          w_avg_num;

    assign w_prod     = i_item.mag * r_gain;
    assign w_out_free = !r_ov || !i_stall;
    assign w_load     = (r_state == S_CLIP) && w_out_free;
    assign o_pop      = (r_state == S_IDLE) && !i_qsts.empty;

    assign w_pos_clip = !r_neg && (r_pm > POS_LIMIT);
    assign w_neg_clip = r_neg && (r_pm > NEG_LIMIT);

    always_comb begin
        w_exc = '0;
        if (w_pos_clip) begin
            w_exc = r_pm - POS_LIMIT;
        end else if (w_neg_clip) begin
            w_exc = r_pm - NEG_LIMIT;
        end
    end

    assign w_sum        = {1'b0, r_excess} + (EXCESS_W + 1)'(w_exc);
    assign w_new_excess = w_sum[EXCESS_W] ? '1 : w_sum[EXCESS_W-1:0];

    always_comb begin
        if (w_pos_clip) begin
            w_sample = OUT_POS_CLIP;
        end else if (w_neg_clip) begin
            w_sample = OUT_NEG_CLIP;
        end else if (r_neg) begin
            w_sample = ~r_pm[OUT_W-1:0] + OUT_W'(1);
        end else begin
            w_sample = r_pm[OUT_W-1:0];
        end
    end

    always_comb begin
        w_new_peak = r_peak;
        if (w_pos_clip) begin
            w_new_peak = PEAK_FULL;
        end else if (!r_neg && (r_pm[PEAK_W-1:0] > r_peak)) begin
            w_new_peak = r_pm[PEAK_W-1:0];
        end
    end

    assign w_f       = {i_cfg.frames, 15'b0} - F_W'(i_cfg.frames);
    assign w_pp      = ACC_W'(r_str * r_excess[{r_k, 4'b0} +: 16]);
    assign w_den     = DEN_W'(r_f) + DEN_W'(r_acc[ACC_W-1:8]);
    assign w_ge      = DSH_W'(r_rem) >= r_dsh;
    assign w_avg_num = REM_W'(r_gain * r_ret) + REM_W'(r_q);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_gain   <= GAIN_ONE;
            r_excess <= '0;
            r_peak   <= '0;
            r_ov     <= 1'b0;
        end else begin
            if (w_load) begin
                r_ov <= 1'b1;
            end else if (r_ov && !i_stall) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (!i_qsts.empty) begin
                        r_pm        <= w_prod[FRAC_W +: MAG_W];
                        r_neg       <= i_item.neg;
                        r_last      <= i_item.last;
                        r_gain_used <= r_gain;
                        r_state     <= S_CLIP;
                    end
                end
                S_CLIP: begin
                    if (w_out_free) begin
                        r_out_sample <= w_sample;
                        r_out_clip   <= w_pos_clip || w_neg_clip;
                        r_out_end    <= r_last;
                        r_out_peak   <= r_last ? w_new_peak : '0;
                        r_out_gain   <= r_gain_used;
                        r_excess     <= w_new_excess;
                        r_peak       <= r_last ? '0 : w_new_peak;
                        if (r_last) begin
                            r_f     <= w_f;
                            r_str   <= i_cfg.strength;
                            r_ret   <= i_cfg.retain;
                            r_acc   <= '0;
                            r_k     <= 2'd2;
                            r_state <= S_MULX;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_MULX: begin
                    r_acc <= {r_acc[ACC_W-17:0], 16'b0} + w_pp;
                    r_k   <= r_k - 2'd1;
                    if (r_k == 2'd0) begin
                        r_state <= S_DEN;
                    end
                end
                S_DEN: begin
                    r_dsh    <= {w_den, 16'b0};
                    r_rem    <= {r_f, 16'b0};
                    r_cnt    <= 5'd16;
                    r_phase  <= 1'b0;
                    r_excess <= '0;
                    r_state  <= S_DIV;
                end
                S_DIV: begin
                    if (w_ge) begin
                        r_rem <= r_rem - r_dsh[REM_W-1:0];
                    end
                    r_q   <= {r_q[QUO_W-2:0], w_ge};
                    r_dsh <= r_dsh >> 1;
                    r_cnt <= r_cnt - 5'd1;
                    if (r_cnt == 5'd0) begin
                        r_state <= r_phase ? S_GAIN : S_AVG;
                    end
                end
                S_AVG: begin
                    r_rem   <= w_avg_num;
                    r_dsh   <= {DEN_W'(r_ret) + DEN_W'(1), 16'b0};
                    r_cnt   <= 5'd16;
                    r_phase <= 1'b1;
                    r_state <= S_DIV;
                end
                S_GAIN: begin
                    r_gain  <= (r_q > GAIN_ONE) ? GAIN_ONE : r_q;
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid          = r_ov;
    assign o_clipped_sample = r_out_sample;
    assign o_was_clipped    = r_out_clip;
    assign o_chunk_end      = r_out_end;
    assign o_chunk_peak     = r_out_peak;
    assign o_gain_used      = r_out_gain;

endmodule

### rtl/adaptive_gain_clipper.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adaptive_gain_clipper
// Applies an adaptive Q1.16 gain to 32-bit audio words and clips to 16 bits.
// ----------------------------------------------------------------------------
// In the back part a word normally passes through the gain multiply and then
// the clip and excess update, and the back part takes no new word until it is
// through with the last one. The last word of a chunk adds the gain update
// (three partial products of strength times excess, then two 17-step passes of
// the shared divider); during that time the two-entry queue fills and input
// transfers stall. Results leave through an output register, so the next word
// can be worked on while a result waits to be taken.
module adaptive_gain_clipper #(
    parameter int MAX_CHUNK_FRAMES = 4096
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic signed [agc_pkg::SAMPLE_W-1:0]  i_mixed_sample,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic signed [agc_pkg::OUT_W-1:0]     o_clipped_sample,
    output logic                                 o_was_clipped,
    output logic                                 o_chunk_end,
    output logic [agc_pkg::PEAK_W-1:0]           o_chunk_peak,
    output logic [agc_pkg::GAIN_W-1:0]           o_gain_used,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [agc_pkg::ADDR_W-1:0]           paddr,
    input  logic [agc_pkg::DATA_W-1:0]           pwdata,
    output logic [agc_pkg::DATA_W-1:0]           prdata,
    output logic                                 pready
);
    import agc_pkg::*;

    localparam int WC_W = (MAX_CHUNK_FRAMES > 1) ? $clog2(2 * MAX_CHUNK_FRAMES) : 1;

    logic [CFG_FRAMES_W-1:0]   r_frames;
    logic [CFG_RETAIN_W-1:0]   r_retain;
    logic [CFG_STRENGTH_W-1:0] r_strength;
    logic [CFG_FRAMES_W-1:0]   w_eff_frames;
    logic [1:0]                w_index;
    logic                      w_wr;
    t_cfg                      w_cfg;
    t_qctl                     w_qctl;
    t_qsts                     w_qsts;
    t_item                     w_push_item;
    t_item                     w_head_item;
    logic                      w_push;
    logic                      w_pop;

    assign pready  = 1'b1;
    assign w_index = paddr[3:2];
    assign w_wr    = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frames   <= CFG_FRAMES_W'(1024);
            r_retain   <= CFG_RETAIN_W'(8);
            r_strength <= CFG_STRENGTH_W'(256);
        end else if (w_wr) begin
            case (w_index)
                REG_FRAMES:   r_frames   <= pwdata[CFG_FRAMES_W-1:0];
                REG_RETAIN:   r_retain   <= pwdata[CFG_RETAIN_W-1:0];
                REG_STRENGTH: r_strength <= pwdata[CFG_STRENGTH_W-1:0];
                default:      r_frames   <= r_frames;
            endcase
        end
    end

    always_comb begin
        case (w_index)
            REG_FRAMES:   prdata = DATA_W'(r_frames);
            REG_RETAIN:   prdata = DATA_W'(r_retain);
            REG_STRENGTH: prdata = DATA_W'(r_strength);
            default:      prdata = '0;
        endcase
    end

    always_comb begin
        if (r_frames == '0) begin
            w_eff_frames = CFG_FRAMES_W'(1);
        end else if (32'(r_frames) > 32'(MAX_CHUNK_FRAMES)) begin
            w_eff_frames = CFG_FRAMES_W'(MAX_CHUNK_FRAMES);
        end else begin
            w_eff_frames = r_frames;
        end
    end

    assign w_cfg.frames   = w_eff_frames;
    assign w_cfg.retain   = r_retain;
    assign w_cfg.strength = r_strength;
    assign w_qctl.push    = w_push;
    assign w_qctl.pop     = w_pop;

    agc_front #(
        .WC_W (WC_W)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .i_mixed_sample (i_mixed_sample),
        .o_stall        (o_stall),
        .i_frames       (w_eff_frames),
        .i_full         (w_qsts.full),
        .o_push         (w_push),
        .o_item         (w_push_item)
    );

    agc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_qctl),
        .i_item  (w_push_item),
        .o_sts   (w_qsts),
        .o_item  (w_head_item)
    );

    agc_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (w_cfg),
        .i_qsts           (w_qsts),
        .i_item           (w_head_item),
        .o_pop            (w_pop),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_clipped_sample (o_clipped_sample),
        .o_was_clipped    (o_was_clipped),
        .o_chunk_end      (o_chunk_end),
        .o_chunk_peak     (o_chunk_peak),
        .o_gain_used      (o_gain_used)
    );

endmodule

### rtl/agc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// agc_checker
// Port-level checks on the result channel of the adaptive gain clipper.
// ----------------------------------------------------------------------------
module agc_checker (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 o_valid,
    input  logic                                 i_stall,
    input  logic signed [agc_pkg::OUT_W-1:0]     o_clipped_sample,
    input  logic                                 o_was_clipped,
    input  logic                                 o_chunk_end,
    input  logic [agc_pkg::PEAK_W-1:0]           o_chunk_peak,
    input  logic [agc_pkg::GAIN_W-1:0]           o_gain_used
);
    import agc_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_clipped_sample)
            && $stable(o_was_clipped) && $stable(o_chunk_end)
            && $stable(o_chunk_peak) && $stable(o_gain_used))
        else $error("result changed during a stalled transfer");

    a_peak_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_chunk_end |-> o_chunk_peak == '0)
        else $error("chunk peak set outside a chunk end");

    a_clip_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_was_clipped |-> o_clipped_sample == 16'sh7FFF
            || o_clipped_sample == -16'sh8000)
        else $error("clipped result not at a clip level");

    a_gain_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_gain_used <= GAIN_ONE)
        else $error("gain above unity");

    a_clip_peak: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_chunk_end && o_was_clipped && o_clipped_sample == 16'sh7FFF
            |-> o_chunk_peak == PEAK_FULL)
        else $error("positive clip at chunk end without full peak");

endmodule

bind adaptive_gain_clipper agc_checker u_agc_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_valid          (o_valid),
    .i_stall          (i_stall),
    .o_clipped_sample (o_clipped_sample),
    .o_was_clipped    (o_was_clipped),
    .o_chunk_end      (o_chunk_end),
    .o_chunk_peak     (o_chunk_peak),
    .o_gain_used      (o_gain_used)
);
